// File: sv/assignment_brute_force_search_defines.svh
// Assertion macros used by the block's top-level RTL.
`ifndef ASSIGNMENT_BRUTE_FORCE_SEARCH_DEFINES_SVH
`define ASSIGNMENT_BRUTE_FORCE_SEARCH_DEFINES_SVH

// Same-cycle implication, reset-masked.
`define ABFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset-masked.
`define ABFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/abfs_pkg.sv
package abfs_pkg;

   localparam int MAX_N_DEFAULT     = 8;
   localparam int COST_BITS_DEFAULT = 16;

   localparam int PERSON_W   = 3;
   localparam int JOB_W      = 3;
   localparam int COST_IN_W  = 16;
   localparam int MIN_COST_W = 19;
   localparam int OP_COUNT_W = 19;
   localparam int SIZE_W     = 4;
   // wide enough for row * MAX_N + column with 3-bit row and column
   localparam int ADDR_CALC_W = 7;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

   typedef struct packed {
      logic [PERSON_W-1:0]  person;
      logic [JOB_W-1:0]     job;
      logic [COST_IN_W-1:0] cost;
      logic                 end_of_matrix;
   } req_type;

   typedef struct packed {
      logic [PERSON_W-1:0]   person_out;
      logic [JOB_W-1:0]      job_out;
      logic [MIN_COST_W-1:0] min_cost;
      logic [OP_COUNT_W-1:0] operation_count;
      logic                  last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SUM_RD,
      ST_SUM_ADD,
      ST_CMP,
      ST_PIVOT,
      ST_PICK,
      ST_REV,
      ST_EMIT
   } state_type;

   // sequencer -> permutation unit
   typedef struct packed {
      logic init;
      logic find_pivot;
      logic swap_pick;
      logic rev_step;
   } perm_ctrl_type;

   // permutation unit -> sequencer
   typedef struct packed {
      logic pivot_found;
      logic rev_more;
   } perm_stat_type;

endpackage

// File: sv/assignment_brute_force_search.sv
// Exhaustive assignment solver. Load an N by N cost matrix one item per
// cycle while req_ready is high (person = row, job = column; entries with
// row or column of MAX_N or above are dropped). The item with end_of_matrix set
// is stored and then starts the search: every permutation of jobs is
// visited in lexicographic order from the identity, and the first one with
// the strictly lowest total cost is kept. N result items follow, one per
// person in order, each with the assigned job, the minimum cost and the
// number of cost additions (N * N!), both truncated to 19 bits; the last
// one carries last_result. N comes from csr_wdata via csr_we (0 acts as 1,
// above MAX_N acts as MAX_N), sampled when the search starts. A search
// runs a setup step, then for each permutation the cost reads and adds
// through the single matrix read port and one adder, a compare, a pivot
// search, an exchange and the suffix reversal swaps (the last permutation
// stops after its pivot search). Results then leave at one per cycle when
// rsp_ready is high. req_ready stays low from the final entry until the
// last result is in the output register. Entries read by a search must
// have been loaded.
`include "assignment_brute_force_search_defines.svh"

module assignment_brute_force_search #(
   parameter int MAX_N     = abfs_pkg::MAX_N_DEFAULT,
   parameter int COST_BITS = abfs_pkg::COST_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  abfs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output abfs_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [abfs_pkg::SIZE_W-1:0]   csr_wdata
);

   localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW    = $clog2(MAX_N + 1);
   localparam int DEPTH = MAX_N * MAX_N;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = COST_BITS + 3;   // up to 8 terms
   localparam int ACW   = abfs_pkg::ADDR_CALC_W;

   // cost matrix: one write port (load), one registered read port (search)
   logic [COST_BITS-1:0] mem [DEPTH];
   logic [COST_BITS-1:0] rd_data_ff;

   abfs_pkg::state_type state_ff, state_in;

   logic [abfs_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] best_ff, best_in;
   logic             first_ff, first_in;
   logic [abfs_pkg::OP_COUNT_W-1:0] ops_ff, ops_in;
   logic [MAX_N-1:0][IW-1:0] best_perm_ff, best_perm_in;
   logic             rsp_valid_ff, rsp_valid_in;
   abfs_pkg::rsp_type rsp_ff, rsp_in;

   abfs_pkg::perm_ctrl_type  pctrl;
   abfs_pkg::perm_stat_type  pstat;
   logic [IW-1:0]            perm_rd;
   logic [MAX_N-1:0][IW-1:0] perm_cur;

   logic req_fire;
   logic wr_ok;
   logic [ACW-1:0] wr_addr, rd_addr;
   logic [COST_BITS+abfs_pkg::COST_IN_W-1:0] cost_wide;
   logic [CW-1:0] n_m1;
   logic          idx_last;
   logic          emit_load;
   logic [CW-1:0] n_active;
   logic [SUM_W+abfs_pkg::MIN_COST_W-1:0] best_wide;
   logic [IW+abfs_pkg::PERSON_W-1:0] person_wide;
   logic [IW+abfs_pkg::JOB_W-1:0]    job_wide;

   abfs_perm_unit #(
      .MAX_N (MAX_N)
   ) u_perm (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (pctrl),
      .n      (n_ff),
      .rd_idx (idx_ff),
      .rd_val (perm_rd),
      .perm_q (perm_cur),
      .stat   (pstat)
   );

   assign req_fire = req_valid && req_ready;
   assign wr_ok    = (int'(req_data.person) < MAX_N) && (int'(req_data.job) < MAX_N);
   assign wr_addr  = ACW'(req_data.person) * ACW'(MAX_N) + ACW'(req_data.job);
   assign rd_addr  = ACW'(idx_ff) * ACW'(MAX_N) + ACW'(perm_rd);
   assign cost_wide = {{COST_BITS{1'b0}}, req_data.cost};
   assign n_m1     = n_ff - CW'(1);
   assign idx_last = (idx_ff == n_m1[IW-1:0]);
   assign emit_load = !rsp_valid_ff || rsp_ready;

   // clamp the size register into 1..MAX_N
   always_comb begin
      if (size_ff == '0) begin
         n_active = CW'(1);
      end else if (int'(size_ff) > MAX_N) begin
         n_active = CW'(MAX_N);
      end else begin
         n_active = CW'(size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && wr_ok) begin
         mem[wr_addr[AW-1:0]] <= cost_wide[COST_BITS-1:0];
      end
      if (state_ff == abfs_pkg::ST_SUM_RD) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abfs_pkg::ST_IDLE: begin
            if (req_fire && req_data.end_of_matrix) state_in = abfs_pkg::ST_INIT;
         end
         abfs_pkg::ST_INIT:    state_in = abfs_pkg::ST_SUM_RD;
         abfs_pkg::ST_SUM_RD:  state_in = abfs_pkg::ST_SUM_ADD;
         abfs_pkg::ST_SUM_ADD: begin
            state_in = idx_last ? abfs_pkg::ST_CMP : abfs_pkg::ST_SUM_RD;
         end
         abfs_pkg::ST_CMP:     state_in = abfs_pkg::ST_PIVOT;
         abfs_pkg::ST_PIVOT: begin
            state_in = pstat.pivot_found ? abfs_pkg::ST_PICK : abfs_pkg::ST_EMIT;
         end
         abfs_pkg::ST_PICK:    state_in = abfs_pkg::ST_REV;
         abfs_pkg::ST_REV: begin
            if (!pstat.rev_more) state_in = abfs_pkg::ST_SUM_RD;
         end
         abfs_pkg::ST_EMIT: begin
            if (emit_load && idx_last) state_in = abfs_pkg::ST_IDLE;
         end
         default:              state_in = abfs_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready        = (state_ff == abfs_pkg::ST_IDLE);
      pctrl            = '0;
      pctrl.init       = (state_ff == abfs_pkg::ST_INIT);
      pctrl.find_pivot = (state_ff == abfs_pkg::ST_PIVOT);
      pctrl.swap_pick  = (state_ff == abfs_pkg::ST_PICK);
      pctrl.rev_step   = (state_ff == abfs_pkg::ST_REV);
   end

   assign best_wide   = {{abfs_pkg::MIN_COST_W{1'b0}}, best_ff};
   assign person_wide = {{abfs_pkg::PERSON_W{1'b0}}, idx_ff};
   assign job_wide    = {{abfs_pkg::JOB_W{1'b0}}, best_perm_ff[idx_ff]};

   // datapath: one adder/comparator shared by every permutation
   always_comb begin
      size_in      = csr_we ? csr_wdata : size_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      first_in     = first_ff;
      ops_in       = ops_ff;
      best_perm_in = best_perm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         abfs_pkg::ST_IDLE: begin
            if (req_fire && req_data.end_of_matrix) n_in = n_active;
         end
         abfs_pkg::ST_INIT: begin
            for (int i = 0; i < MAX_N; i++) best_perm_in[i] = IW'(i);
            first_in = 1'b1;
            ops_in   = '0;
            sum_in   = '0;
            idx_in   = '0;
         end
         abfs_pkg::ST_SUM_ADD: begin
            sum_in = sum_ff + SUM_W'(rd_data_ff);
            ops_in = ops_ff + 1'b1;
            idx_in = idx_last ? '0 : idx_ff + IW'(1);
         end
         abfs_pkg::ST_CMP: begin
            if (first_ff || (sum_ff < best_ff)) begin
               best_in      = sum_ff;
               best_perm_in = perm_cur;
            end
            first_in = 1'b0;
            sum_in   = '0;
            idx_in   = '0;
         end
         abfs_pkg::ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in           = 1'b1;
               rsp_in.person_out      = person_wide[abfs_pkg::PERSON_W-1:0];
               rsp_in.job_out         = job_wide[abfs_pkg::JOB_W-1:0];
               rsp_in.min_cost        = best_wide[abfs_pkg::MIN_COST_W-1:0];
               rsp_in.operation_count = ops_ff;
               rsp_in.last_result     = idx_last;
               idx_in                 = idx_last ? '0 : idx_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abfs_pkg::ST_IDLE;
         size_ff      <= abfs_pkg::SIZE_RESET;
         n_ff         <= CW'(1);
         idx_ff       <= '0;
         first_ff     <= 1'b1;
         ops_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_N; i++) best_perm_ff[i] <= IW'(i);
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         ops_ff       <= ops_in;
         rsp_valid_ff <= rsp_valid_in;
         best_perm_ff <= best_perm_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // final entry always starts a search and closes the input
   `ABFS_ASSERT_NEXT(a_search_start, clock, reset, req_fire && req_data.end_of_matrix, (state_ff == abfs_pkg::ST_INIT) && !req_ready, "final entry did not start a search")
   // no result leaves before a best permutation was recorded
   `ABFS_ASSERT_NOW(a_best_before_emit, clock, reset, state_ff == abfs_pkg::ST_EMIT, !first_ff, "emitting without a best permutation")
   // the flagged result belongs to the last person
   `ABFS_ASSERT_NOW(a_last_person, clock, reset, rsp_valid_ff && rsp_ff.last_result && (state_ff == abfs_pkg::ST_IDLE), rsp_ff.person_out == abfs_pkg::PERSON_W'(n_m1), "last result not for person N-1")

endmodule

// File: sv/abfs_perm_unit.sv
// Current permutation and its lexicographic successor step:
// pivot search, pivot/pick exchange, then suffix reversal one swap a cycle.
module abfs_perm_unit #(
   parameter int MAX_N = abfs_pkg::MAX_N_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  abfs_pkg::perm_ctrl_type     ctrl,
   input  logic [$clog2(MAX_N+1)-1:0]  n,
   input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] rd_idx,
   output logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] rd_val,
   output logic [MAX_N-1:0][((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] perm_q,
   output abfs_pkg::perm_stat_type     stat
);

   localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW = $clog2(MAX_N + 1);

   logic [MAX_N-1:0][IW-1:0] perm_ff, perm_in;
   logic [IW-1:0] pivot_ff, pivot_in;
   logic [IW-1:0] pv_ff, pv_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;

   logic [MAX_N-1:0] asc;
   logic [MAX_N-1:0] gt;
   logic [IW-1:0]    pivot_idx;
   logic [IW-1:0]    pick_idx;
   logic [CW-1:0]    n_m1;

   assign n_m1   = n - CW'(1);
   assign rd_val = perm_ff[rd_idx];
   assign perm_q = perm_ff;

   // rising neighbor pairs inside the active prefix; highest one is the pivot
   always_comb begin
      asc       = '0;
      pivot_idx = '0;
      for (int k = 0; k < MAX_N - 1; k++) begin
         asc[k] = ((k + 2) <= int'(n)) && (perm_ff[k] < perm_ff[k+1]);
      end
      for (int k = 0; k < MAX_N; k++) begin
         if (asc[k]) pivot_idx = IW'(k);
      end
   end

   // suffix is descending, so the last entry above the pivot value is the smallest one
   always_comb begin
      gt       = '0;
      pick_idx = '0;
      for (int j = 0; j < MAX_N; j++) begin
         gt[j] = (IW'(j) > pivot_ff) && (j < int'(n)) && (perm_ff[j] > pv_ff);
      end
      for (int j = 0; j < MAX_N; j++) begin
         if (gt[j]) pick_idx = IW'(j);
      end
   end

   assign stat.pivot_found = |asc;
   assign stat.rev_more    = lo_ff < hi_ff;

   always_comb begin
      perm_in  = perm_ff;
      pivot_in = pivot_ff;
      pv_in    = pv_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (ctrl.init) begin
         for (int i = 0; i < MAX_N; i++) perm_in[i] = IW'(i);
      end
      if (ctrl.find_pivot) begin
         pivot_in = pivot_idx;
         pv_in    = perm_ff[pivot_idx];
      end
      if (ctrl.swap_pick) begin
         perm_in[pivot_ff] = perm_ff[pick_idx];
         perm_in[pick_idx] = pv_ff;
         lo_in = pivot_ff + IW'(1);
         hi_in = n_m1[IW-1:0];
      end
      if (ctrl.rev_step && stat.rev_more) begin
         perm_in[lo_ff] = perm_ff[hi_ff];
         perm_in[hi_ff] = perm_ff[lo_ff];
         lo_in = lo_ff + IW'(1);
         hi_in = hi_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_N; i++) perm_ff[i] <= IW'(i);
      end else begin
         perm_ff <= perm_in;
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
      pv_ff    <= pv_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

// Testbench for the brute-force assignment solver.
// A short table of hand-picked matrix entries comes first. Random search
// phases follow: each one loads whatever part of the active N by N matrix
// has never been written, rewrites a few entries, scatters noise entries,
// and closes with a marked entry that starts the search. The last phase
// runs the full 8 by 8 search through an oversize setting. Every result
// item is checked field by field against a local permutation search or a hand-typed row.
module tb;

   localparam int MAX_N         = 8;
   localparam int GRID_DEPTH    = MAX_N * MAX_N;
   localparam int COST_W        = abfs_pkg::COST_IN_W;
   localparam int SETTLE_CYCLES = 8;          // block may still finish an ordinary entry
   localparam int QUIET_LIMIT   = 4_000_000;  // watchdog limit; exceeds the full 8 by 8 search
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 60;         // small phases; the big one adds the rest

   localparam logic [abfs_pkg::SIZE_W-1:0] SIZE_ZERO     = 4'd0;
   localparam logic [abfs_pkg::SIZE_W-1:0] SIZE_OVERSIZE = 4'd15;

   // One row of the directed table. When set_size is high the size register
   // is written (block idle) before the item goes out. When typed is high
   // the single result of this item is known by hand and taken from want.
   typedef struct packed {
      bit                          set_size;
      bit [abfs_pkg::SIZE_W-1:0]   size_val;
      abfs_pkg::req_type           item;
      bit                          typed;
      abfs_pkg::rsp_type           want;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   abfs_pkg::req_type           req_data;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   abfs_pkg::rsp_type           rsp_data;
   logic                        csr_we;
   logic [abfs_pkg::SIZE_W-1:0] csr_wdata;

   // Solver model state.
   bit [abfs_pkg::COST_IN_W-1:0] cost_grid   [GRID_DEPTH];
   bit                           grid_loaded [GRID_DEPTH];
   bit [abfs_pkg::SIZE_W-1:0]    size_reg = abfs_pkg::SIZE_RESET;
   abfs_pkg::rsp_type            due_assignments[$];

   int mismatch_count = 0;
   int burst_left     = 0;
   int random_items   = 0;
   int quiet_cycles   = 0;
   int ready_mode     = 0;
   int ready_timer    = 0;

   // Directed table.
   // Rows 1-16: full 4 by 4 load at the reset size, extremes and bit patterns.
   // Size one with max cost, zero size acting as one, a size-two matrix whose
   // best is the last permutation, then an all-zero tie (identity must win).
   // Last row: size three, marked entry stored outside the active square.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 4'd0, '{3'd0, 3'd0, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd0, 3'd1, 16'h0001, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd0, 3'd2, 16'h8000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd0, 3'd3, 16'h00FF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd0, 16'h0000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd1, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd2, 16'h5555, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd3, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd2, 3'd0, 16'h1234, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd2, 3'd1, 16'h0F0F, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd2, 3'd2, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd2, 3'd3, 16'h0000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd3, 3'd0, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd3, 3'd1, 16'h0002, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd3, 3'd2, 16'h0000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd3, 3'd3, 16'hFFFF, 1'b1}, 1'b0, '0},
      '{1'b1, 4'd1, '{3'd0, 3'd0, 16'hFFFF, 1'b1},
        1'b1, '{3'd0, 3'd0, 19'd65535, 19'd1, 1'b1}},
      '{1'b1, SIZE_ZERO, '{3'd0, 3'd0, 16'h0000, 1'b1},
        1'b1, '{3'd0, 3'd0, 19'd0, 19'd1, 1'b1}},
      '{1'b1, 4'd2, '{3'd0, 3'd0, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd1, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd0, 3'd1, 16'h0000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd0, 16'h0000, 1'b1}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd1, 3'd1, 16'h0000, 1'b0}, 1'b0, '0},
      '{1'b0, 4'd0, '{3'd0, 3'd0, 16'h0000, 1'b1}, 1'b0, '0},
      '{1'b1, 4'd3, '{3'd7, 3'd7, 16'hFFFF, 1'b1}, 1'b0, '0}
   };

   assignment_brute_force_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Size register value -> N actually searched (0 acts as 1, clamp at MAX_N).
   function automatic int active_n(input bit [abfs_pkg::SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_N) return MAX_N;
      return int'(v);
   endfunction

   // Store the entry; on a marked entry run the exhaustive search and queue
   // one expected result per person.
   function automatic void load_and_solve(input abfs_pkg::req_type it);
      int                n, perms, c, i, k, pivot, pick, lo, hi;
      int unsigned       sum, best_sum, adds;
      bit [2:0]          perm [MAX_N];
      bit [2:0]          best [MAX_N];
      bit [2:0]          tmp;
      abfs_pkg::rsp_type r;
      cost_grid[it.person * MAX_N + it.job]   = it.cost;
      grid_loaded[it.person * MAX_N + it.job] = 1'b1;
      if (!it.end_of_matrix) return;
      n = active_n(size_reg);
      perms = 1;
      for (i = 2; i <= n; i++) perms *= i;
      for (i = 0; i < MAX_N; i++) begin
         perm[i] = i[2:0];
         best[i] = i[2:0];
      end
      best_sum = '1;
      adds = 0;
      for (c = 0; c < perms; c++) begin
         sum = 0;
         for (i = 0; i < n; i++) sum += cost_grid[i * MAX_N + perm[i]];
         adds += n;
         // strictly lower only: the first of equal sums is kept
         if (sum < best_sum) begin
            best_sum = sum;
            best = perm;
         end
         if (c + 1 < perms) begin
            // lexicographic successor of perm[0..n-1]
            pivot = 0;
            for (k = n - 2; k >= 0; k--) begin
               if (perm[k] < perm[k + 1]) begin
                  pivot = k;
                  break;
               end
            end
            pick = pivot + 1;
            for (k = pivot + 2; k < n; k++)
               if (perm[k] > perm[pivot] && perm[k] < perm[pick]) pick = k;
            tmp = perm[pivot]; perm[pivot] = perm[pick]; perm[pick] = tmp;
            lo = pivot + 1;
            hi = n - 1;
            while (lo < hi) begin
               tmp = perm[lo]; perm[lo] = perm[hi]; perm[hi] = tmp;
               lo++;
               hi--;
            end
         end
      end
      for (i = 0; i < n; i++) begin
         r.person_out      = i[2:0];
         r.job_out         = best[i];
         r.min_cost        = best_sum[abfs_pkg::MIN_COST_W-1:0];
         r.operation_count = adds[abfs_pkg::OP_COUNT_W-1:0];
         r.last_result     = (i == n - 1);
         due_assignments.push_back(r);
      end
   endfunction

   // Present one item and hold it until accepted. The sender runs in bursts;
   // between bursts valid drops for a random gap (sometimes none at all).
   task automatic send_item(input abfs_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      load_and_solve(it);
      burst_left--;
   endtask

   // Stop sending, let every expected result drain, then give the block a
   // few cycles to finish any trailing ordinary entry.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (due_assignments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input bit [abfs_pkg::SIZE_W-1:0] v);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      size_reg = v;
   endtask

   // Biased cost: extremes, tiny values that force ties, or anything.
   function automatic bit [abfs_pkg::COST_IN_W-1:0] pick_cost();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return COST_W'($urandom_range(0, 3));
         default: return COST_W'($urandom);
      endcase
   endfunction

   // One random search: fill unwritten active entries, rewrite a few,
   // throw in noise anywhere in the grid, shuffle, then the marked entry.
   task automatic run_search(input bit [abfs_pkg::SIZE_W-1:0] size_val);
      abfs_pkg::req_type plan[$];
      abfs_pkg::req_type it, tmp;
      int                n, p, j, i, extra;
      write_size(size_val);
      n = active_n(size_val);
      for (p = 0; p < n; p++) begin
         for (j = 0; j < n; j++) begin
            if (!grid_loaded[p * MAX_N + j]) begin
               it = '{p[2:0], j[2:0], pick_cost(), 1'b0};
               plan.push_back(it);
            end
         end
      end
      extra = $urandom_range(0, 4);
      for (i = 0; i < extra; i++) begin
         it = '{3'($urandom_range(0, n - 1)), 3'($urandom_range(0, n - 1)),
                pick_cost(), 1'b0};
         plan.push_back(it);
      end
      extra = $urandom_range(0, 2);
      for (i = 0; i < extra; i++) begin
         it = '{3'($urandom_range(0, MAX_N - 1)), 3'($urandom_range(0, MAX_N - 1)),
                pick_cost(), 1'b0};
         plan.push_back(it);
      end
      for (i = plan.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = plan[i];
         plan[i] = plan[j];
         plan[j] = tmp;
      end
      // marked entry: usually inside the active square, sometimes anywhere
      if ($urandom_range(0, 4) == 0)
         it = '{3'($urandom_range(0, MAX_N - 1)), 3'($urandom_range(0, MAX_N - 1)),
                pick_cost(), 1'b1};
      else
         it = '{3'($urandom_range(0, n - 1)), 3'($urandom_range(0, n - 1)),
                pick_cost(), 1'b1};
      plan.push_back(it);
      foreach (plan[i]) begin
         send_item(plan[i]);
         random_items++;
      end
   endtask

   // Receiver: picks a new mode each time its timer runs out: always ready,
   // coin flip, or mostly stalled.
   always @(posedge clock) begin
      if (ready_timer == 0) begin
         ready_mode  <= $urandom_range(0, 2);
         ready_timer <= 128;
      end else begin
         ready_timer <= ready_timer - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Result check against the oldest expectation, plus the quiet-cycle watchdog.
   always @(posedge clock) begin
      abfs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_assignments.size() == 0) begin
            $display("%0t unexpected result item %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = due_assignments.pop_front();
            if (rsp_data.person_out !== want.person_out) begin
               $display("%0t person_out expected %0d got %0d",
                        $time, want.person_out, rsp_data.person_out);
               mismatch_count++;
            end
            if (rsp_data.job_out !== want.job_out) begin
               $display("%0t job_out expected %0d got %0d",
                        $time, want.job_out, rsp_data.job_out);
               mismatch_count++;
            end
            if (rsp_data.min_cost !== want.min_cost) begin
               $display("%0t min_cost expected %0d got %0d",
                        $time, want.min_cost, rsp_data.min_cost);
               mismatch_count++;
            end
            if (rsp_data.operation_count !== want.operation_count) begin
               $display("%0t operation_count expected %0d got %0d",
                        $time, want.operation_count, rsp_data.operation_count);
               mismatch_count++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $display("%0t last_result expected %0d got %0d",
                        $time, want.last_result, rsp_data.last_result);
               mismatch_count++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int row;
      int pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].set_size) write_size(directed_rows[row].size_val);
         send_item(directed_rows[row].item);
         if (directed_rows[row].typed) begin
            void'(due_assignments.pop_back());
            due_assignments.push_back(directed_rows[row].want);
         end
      end

      // random searches, mostly small N
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       run_search(SIZE_ZERO);
            1:       run_search(4'd1);
            2, 3:    run_search(4'd2);
            4, 5:    run_search(4'd3);
            6, 7:    run_search(4'd4);
            8:       run_search(4'd5);
            default: run_search(4'd6);
         endcase
      end
      // oversize setting clamps to the full 8 by 8 search
      run_search(SIZE_OVERSIZE);

      wait_for_idle();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/abfs_pkg.sv
sv/abfs_perm_unit.sv
sv/assignment_brute_force_search.sv
sim/tb.sv
